[rtl/sm3_pkg.sv]
// Package with the SM3 hash engine types and constants.
package sm3_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_EXP,
    ST_RND,
    ST_FIN,
    ST_OUT
  } state_e;

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef logic [31:0] word_t;

  function automatic word_t sm3_iv(input logic [2:0] idx);
    word_t r;
    case (idx)
      3'd0: r = 32'h7380166F;
      3'd1: r = 32'h4914B2B9;
      3'd2: r = 32'h172442D7;
      3'd3: r = 32'hDA8A0600;
      3'd4: r = 32'hA96F30BC;
      3'd5: r = 32'h163138AA;
      3'd6: r = 32'hE38DEE4D;
      default: r = 32'hB0FB0E4E;
    endcase
    return r;
  endfunction

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

[rtl/sm3_hash_engine.sv]
// Top level of the SM3 hash engine: byte packing, expansion, rounds, digest output.
//
// Input channel s_axis: tdata carries message_word (first byte in bits 31:24),
// tuser carries byte_count (0..4, values above 4 count as 4), tlast marks the
// final word of a message. Output channel m_axis: tdata carries digest_word,
// tuser carries word_index, tlast marks the eighth digest word.
// A word is accepted, its valid bytes are written into the block buffer one
// at a time, and a closing step follows. Each 64-byte block then loads
// W0..W15 and expands W16..W67 into the expansion memory, runs the 64 rounds
// and a closing round step, and folds the result into the chaining value.
// Throughput is set by the byte-serial packing and the one-round-per-cycle
// datapath.
// On a final word the engine pads with 0x80, zeros and the bit length (one
// byte per cycle, plus one or two compressions), then presents the eight
// digest words one per transaction and returns to the initial vector.
// Only one item is worked on at a time; s_axis_tready is low while busy.
// If the receiver stalls, the current digest word holds on m_axis until taken.
// Reset sets the initial vector, clears the length and the fill position;
// the block and expansion memories need no clearing.
module sm3_hash_engine
  import sm3_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] message_word
  input  logic [2:0]  s_axis_tuser,   // [2:0] byte_count
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast
);

  // padding phases
  localparam logic [3:0] PAD_LEN  = 4'd0;   // zeros, then the length trailer
  localparam logic [3:0] PAD_MARK = 4'd8;   // 0x80 pending
  localparam logic [3:0] PAD_DONE = 4'd9;   // trailer written
  localparam logic [3:0] PAD_WRAP = 4'd10;  // zeros to the end of this block

  state_e      state_q, state_d;
  word_t       cv_q [8];
  word_t       wr_q [8];
  logic [63:0] len_q, len_d, flen_q, flen_d;
  logic [5:0]  pos_q, pos_d;
  logic [31:0] word_q, word_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        last_q, last_d;
  logic [3:0]  pad_q, pad_d;     // padding phase
  logic        padding_q, padding_d;
  logic [6:0]  j_q, j_d;
  logic [2:0]  oidx_q, oidx_d;

  // block buffer kept in flip-flops: read by word index in the expansion step
  word_t       blk_q [16];

  // expansion memory: one write port, one registered read port
  word_t       wmem [68];
  logic        we;
  logic [6:0]  waddr;
  word_t       wdata;
  logic [6:0]  raddr;
  word_t       rdata_q;
  // 16-entry window of recent W words for the recurrence; W[j..j+3] in rounds
  word_t       win_q [16];

  // byte insertion
  logic        push;
  logic [7:0]  pbyte;

  always_comb begin
    pbyte = 8'h00;
    if (!padding_q) pbyte = word_q[31:24];
    else if (pad_q == PAD_MARK) pbyte = PAD_BYTE;
    else if (pad_q == PAD_LEN && pos_q >= 6'd56)
      pbyte = flen_q[8'd63 - {pos_q[2:0], 3'b000} -: 8];
    else pbyte = 8'h00;
  end

  // round datapath
  word_t a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, tt1, tt2, tj, wj, wj4;
  word_t wnew;

  always_comb begin
    wnew = perm1(win_q[0] ^ win_q[7] ^ rotl(win_q[13], 5'd15))
           ^ rotl(win_q[3], 5'd7) ^ win_q[10];
  end

  always_comb begin
    a = wr_q[0]; b = wr_q[1]; c = wr_q[2]; d = wr_q[3];
    e = wr_q[4]; f = wr_q[5]; g = wr_q[6]; h = wr_q[7];
    tj  = (j_q < 7'd16) ? T_LOW : T_HIGH;
    a12 = rotl(a, 5'd12);
    ss1 = rotl(a12 + e + rotl(tj, j_q[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (j_q < 7'd16) begin
      ff = a ^ b ^ c;
      gg = e ^ f ^ g;
    end else begin
      ff = (a & b) | (a & c) | (b & c);
      gg = (e & f) | (~e & g);
    end
    wj  = win_q[0];
    wj4 = rdata_q;
    tt1 = ff + d + ss2 + (wj ^ wj4);
    tt2 = gg + h + ss1 + wj;
  end

  // control
  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    flen_d    = flen_q;
    pos_d     = pos_q;
    word_d    = word_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    pad_d     = pad_q;
    padding_d = padding_q;
    j_d       = j_q;
    oidx_d    = oidx_q;
    push      = 1'b0;
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_OUT);
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          word_d    = s_axis_tdata;
          cnt_d     = (s_axis_tuser > 3'd4) ? 3'd4 : s_axis_tuser;
          last_d    = s_axis_tlast;
          padding_d = 1'b0;
          state_d   = ST_PAD;
        end
      end
      ST_PAD: begin
        if (!padding_q) begin
          if (cnt_q == 3'd0) begin
            if (last_q) begin
              padding_d = 1'b1;
              pad_d     = PAD_MARK;
              flen_d    = len_q;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            push   = 1'b1;
            len_d  = len_q + 64'd8;
            word_d = {word_q[23:0], 8'h00};
            cnt_d  = cnt_q - 3'd1;
          end
        end else begin
          push = 1'b1;
          // a marker past byte 55 leaves no room for the trailer in this block
          if (pad_q == PAD_MARK) begin
            pad_d = (pos_q >= 6'd56 && pos_q != 6'd63) ? PAD_WRAP : PAD_LEN;
          end else if (pos_q == 6'd63) begin
            pad_d = (pad_q == PAD_WRAP) ? PAD_LEN : PAD_DONE;
          end
        end
        pos_d = pos_q + {5'd0, push};
        if (push && (pos_q == 6'd63)) begin
          j_d     = 7'd0;
          state_d = ST_EXP;
        end
      end
      ST_EXP: begin
        // write W0..W15, then W16..W67, while the window slides
        j_d = j_q + 7'd1;
        if (j_q == 7'd67) begin
          j_d     = 7'd0;
          state_d = ST_RND;
        end
      end
      ST_RND: begin
        j_d = j_q + 7'd1;
        if (j_q == 7'd64) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (padding_q && pad_q == PAD_DONE) begin
          oidx_d  = 3'd0;
          state_d = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            len_d     = 64'd0;
            pos_d     = 6'd0;
            padding_d = 1'b0;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // expansion memory port use: read W[j+5] during round j, W4 before round 0
  always_comb begin
    we    = 1'b0;
    waddr = j_q;
    wdata = (j_q < 7'd16) ? blk_q[j_q[3:0]] : wnew;
    raddr = j_q + 7'd5;
    if (raddr > 7'd67) raddr = 7'd0;
    if (state_q == ST_EXP) we = 1'b1;
    if (state_q == ST_EXP && j_q == 7'd67) raddr = 7'd4;
  end

  always_ff @(posedge clk_i) begin
    if (we) wmem[waddr] <= wdata;
    rdata_q <= wmem[raddr];
  end

  // window and buffer payload
  always_ff @(posedge clk_i) begin
    if (push) blk_q[pos_q[5:2]][8'd31 - {pos_q[1:0], 3'b000} -: 8] <= pbyte;
    if (state_q == ST_EXP) begin
      if (j_q < 7'd16) begin
        for (int k = 0; k < 15; k++) win_q[k] <= win_q[k + 1];
        win_q[15] <= blk_q[j_q[3:0]];
      end else if (j_q != 7'd67) begin
        for (int k = 0; k < 15; k++) win_q[k] <= win_q[k + 1];
        win_q[15] <= wnew;
      end else begin
        for (int k = 0; k < 4; k++) win_q[k] <= blk_q[k];
      end
    end else if (state_q == ST_RND && j_q != 7'd64) begin
      for (int k = 0; k < 3; k++) win_q[k] <= win_q[k + 1];
      win_q[3] <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      for (int k = 0; k < 8; k++) begin
        cv_q[k] <= sm3_iv(3'(k));
        wr_q[k] <= '0;
      end
      len_q     <= '0;
      flen_q    <= '0;
      pos_q     <= '0;
      word_q    <= '0;
      cnt_q     <= '0;
      last_q    <= 1'b0;
      pad_q     <= '0;
      padding_q <= 1'b0;
      j_q       <= '0;
      oidx_q    <= '0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      flen_q    <= flen_d;
      pos_q     <= pos_d;
      word_q    <= word_d;
      cnt_q     <= cnt_d;
      last_q    <= last_d;
      pad_q     <= pad_d;
      padding_q <= padding_d;
      j_q       <= j_d;
      oidx_q    <= oidx_d;
      if (state_q == ST_EXP && j_q == 7'd67) begin
        for (int k = 0; k < 8; k++) wr_q[k] <= cv_q[k];
      end
      if (state_q == ST_RND && j_q != 7'd64) begin
        wr_q[0] <= tt1;
        wr_q[1] <= a;
        wr_q[2] <= rotl(b, 5'd9);
        wr_q[3] <= c;
        wr_q[4] <= perm0(tt2);
        wr_q[5] <= e;
        wr_q[6] <= rotl(f, 5'd19);
        wr_q[7] <= g;
      end
      if (state_q == ST_FIN) begin
        for (int k = 0; k < 8; k++) cv_q[k] <= cv_q[k] ^ wr_q[k];
      end
      if (state_q == ST_OUT && m_axis_tready && oidx_q == 3'd7) begin
        for (int k = 0; k < 8; k++) cv_q[k] <= sm3_iv(3'(k));
      end
    end
  end

  assign m_axis_tdata = cv_q[oidx_q];
  assign m_axis_tuser = oidx_q;
  assign m_axis_tlast = (oidx_q == 3'd7);

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(oidx_q)))
    else $error("digest word dropped");
  a_rnd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RND) |-> (j_q <= 7'd64)) else $error("round counter overrun");
  a_len_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (len_q == 64'd0 && pos_q == 6'd0))
    else $error("length not cleared after digest");
`endif

endmodule

[test/testbench.sv]
// Self-checking SM3 engine testbench: directed and random messages against a digest predictor.
module testbench
  import sm3_pkg::*;
();

  localparam int unsigned IDLE_LIMIT = 20000;

  // Expected digest word with its position and done flag
  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  index;
    logic        done;
  } digest_beat_t;

  // Predicts SM3 digests from accepted message words and checks output beats
  class digest_scoreboard;
    logic [31:0]  chain_q[8];
    logic [31:0]  block_q[16];
    logic [63:0]  msg_bits;
    int unsigned  byte_pos;
    digest_beat_t pending_q[$];
    int unsigned  mismatch_cnt;

    function new();
      restart();
      mismatch_cnt = 0;
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain_q[i] = sm3_iv(i[2:0]);
      msg_bits = '0;
      byte_pos = 0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int unsigned n);
      n = n % 32;
      return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
    endfunction

    function void compress();
      logic [31:0] w[68];
      logic [31:0] a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, tt1, tt2, tj, p;
      for (int j = 0; j < 16; j++) w[j] = block_q[j];
      for (int j = 16; j < 68; j++) begin
        p = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
        w[j] = p ^ rol(p, 15) ^ rol(p, 23) ^ rol(w[j-13], 7) ^ w[j-6];
      end
      {a, b, c, d, e, f, g, h} = {chain_q[0], chain_q[1], chain_q[2], chain_q[3],
                                  chain_q[4], chain_q[5], chain_q[6], chain_q[7]};
      for (int j = 0; j < 64; j++) begin
        tj  = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
        a12 = rol(a, 12);
        ss1 = rol(a12 + e + rol(tj, j), 7);
        ss2 = ss1 ^ a12;
        if (j < 16) begin
          ff = a ^ b ^ c;
          gg = e ^ f ^ g;
        end else begin
          ff = (a & b) | (a & c) | (b & c);
          gg = (e & f) | (~e & g);
        end
        tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
        tt2 = gg + h + ss1 + w[j];
        d = c; c = rol(b, 9); b = a; a = tt1;
        h = g; g = rol(f, 19); f = e;
        e = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
      end
      chain_q[0] ^= a; chain_q[1] ^= b; chain_q[2] ^= c; chain_q[3] ^= d;
      chain_q[4] ^= e; chain_q[5] ^= f; chain_q[6] ^= g; chain_q[7] ^= h;
    endfunction

    function void put_byte(logic [7:0] bt);
      block_q[byte_pos / 4][(3 - byte_pos % 4) * 8 +: 8] = bt;
      byte_pos = (byte_pos + 1) % 64;
      if (byte_pos == 0) compress();
    endfunction

    // Note one accepted message word
    function void note_word(logic [31:0] word, logic [2:0] cnt, logic last);
      int unsigned n;
      logic [63:0] len;
      n = (cnt > 4) ? 4 : cnt;
      for (int i = 0; i < n; i++) begin
        put_byte(word[31 - 8*i -: 8]);
        msg_bits += 64'd8;
      end
      if (!last) return;
      len = msg_bits;
      put_byte(8'h80);
      while (byte_pos != 56) put_byte(8'h00);
      for (int i = 0; i < 8; i++) put_byte(len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++)
        pending_q.push_back(digest_beat_t'{chain_q[i], i[2:0], i == 7});
      restart();
    endfunction

    // Check one output transaction against the oldest expectation
    function void check_beat(logic [31:0] dig, logic [2:0] idx, logic done);
      digest_beat_t exp_b;
      if (pending_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected digest beat %h idx %0d", dig, idx);
        return;
      end
      exp_b = pending_q.pop_front();
      if (exp_b.digest !== dig || exp_b.index !== idx || exp_b.done !== done) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                   exp_b.digest, exp_b.index, exp_b.done, dig, idx, done);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  digest_scoreboard sb = new();
  int unsigned idle_cycles;
  int unsigned hold_off_cycles;
  bit          long_hold;
  bit          stim_done;

  sm3_hash_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] message_word
    .s_axis_tuser  (s_axis_tuser),   // [2:0] byte_count
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] digest_word
    .m_axis_tuser  (m_axis_tuser),   // [2:0] word_index
    .m_axis_tlast  (m_axis_tlast)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one message word and hold it until accepted
  task automatic send_word(logic [31:0] word, logic [2:0] cnt, logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= cnt;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(word, cnt, last);
    @(negedge clk_i);
  endtask

  // Drop valid for a random gap, most often none
  task automatic sender_gap();
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Send a random message: mostly short, occasionally several blocks
  task automatic send_message(int unsigned nwords);
    logic [2:0] cnt;
    for (int unsigned i = 0; i < nwords; i++) begin
      cnt = 3'd4;
      if (i == nwords - 1 || $urandom_range(0, 15) == 0) cnt = 3'($urandom_range(0, 7));
      send_word($urandom, cnt, i == nwords - 1);
      sender_gap();
    end
  endtask

  // Wait until every expected digest word has arrived
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    int unsigned sent;
    int unsigned nwords;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    stim_done     = 1'b0;
    long_hold     = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: "abc", empty message, zero and oversized counts, extremes
    send_word(32'h61626300, 3'd3, 1'b1);
    send_word(32'h00000000, 3'd0, 1'b1);
    send_word(32'hFFFFFFFF, 3'd7, 1'b1);
    send_word(32'hFFFFFFFF, 3'd2, 1'b0);
    send_word(32'h12345678, 3'd1, 1'b0);
    send_word(32'h00000000, 3'd4, 1'b0);
    send_word(32'hA5A5A5A5, 3'd5, 1'b1);
    for (int i = 0; i < 16; i++) send_word(32'h61626364, 3'd4, i == 15);
    send_word(32'h5A5A5A5A, 3'd0, 1'b0);
    send_word(32'h87654321, 3'd6, 1'b1);
    sent = 25;
    drain();

    // Long receiver stall while the sender keeps offering words
    long_hold = 1'b1;
    send_message(20);
    sent += 20;
    wait (!long_hold);
    drain();

    // Random messages
    while (sent < 370) begin
      nwords = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 34) : $urandom_range(1, 6);
      send_message(nwords);
      sent += nwords;
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();
    stim_done = 1'b1;
  end

  // Receiver stall pattern plus one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    hold_off_cycles = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        hold_off_cycles++;
        if (hold_off_cycles == 3000) long_hold = 1'b0;
      end else if (($urandom_range(0, 63) < 16)) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Check output transactions
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Watchdog and end of run
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || long_hold)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (stim_done) begin
        repeat (300) @(posedge clk_i);
        if (sb.mismatch_cnt == 0 && sb.pending_q.size() == 0)
          $display("Testbench completed without errors");
        else
          $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
